### rtl/mdfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdfs_pkg
// Shared types and codes of the depth-first maze generator: item modes,
// directions, register indexes, defaults and the sequencer states.
// ----------------------------------------------------------------------------
package mdfs_pkg;

  // Configuration register width, reset value and largest value it can hold
  localparam int          REG_W      = 6;
  localparam int          REG_MAX    = 63;
  localparam logic [5:0]  GRID_RESET = 6'd16;

  // Configuration register indexes
  localparam int          REG_IDX_W       = 1;
  localparam logic [0:0]  REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0]  REG_GRID_HEIGHT = 1'b1;

  // Default grid bounds
  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 32;

  // Result field widths
  localparam int OUT_COORD_W = 5;
  localparam int WALL_W      = 4;

  // Item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_MOVE  = 2'd2;

  // Directions, also the wall bit positions
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_T_LOAD,
    ST_DIV,
    ST_B_RDC,
    ST_B_EVC,
    ST_B_RDN,
    ST_B_EVN,
    ST_B_WRN,
    ST_B_RDP,
    ST_B_EVP,
    ST_P_MUL,
    ST_P_RD,
    ST_P_EV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

### rtl/maze_dfs_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// maze_dfs_generator
// Randomized depth-first backtracking maze builder with a player walker.
// All cell state (walls, untried directions, visited, parent) lives in one
// synchronous cell memory; a sequencer reads, modifies and writes it back.
// ----------------------------------------------------------------------------
//
//  channel   signals                                    direction
//  --------  -----------------------------------------  ---------
//  item      item_valid, item_stall, mode, dir          in
//  result    result_valid, result_stall, build_done,    out
//            cursor_x, cursor_y, player_x, player_y,
//            player_walls, moved
//  config    cfg_we, cfg_index, cfg_data                in
//
// Every item ends with a cursor division (one quotient bit per cycle) plus a
// player-cell lookup. A build step on an open walk adds a second division and
// 1 to 4 cell-memory accesses; a move adds a first player-cell lookup; a start
// item adds a sweep that initialises every cell. After reset a clearing pass
// zeroes the cell memory; items wait, configuration writes are taken. A stalled
// result holds the block in its final state; one item is in flight at a time.
// ----------------------------------------------------------------------------
module maze_dfs_generator #(
  parameter int MAX_WIDTH  = mdfs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mdfs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // item channel
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [1:0]                          mode,
  input  logic [1:0]                          dir,
  // result channel
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                build_done,
  output logic [mdfs_pkg::OUT_COORD_W-1:0]    cursor_x,
  output logic [mdfs_pkg::OUT_COORD_W-1:0]    cursor_y,
  output logic [mdfs_pkg::OUT_COORD_W-1:0]    player_x,
  output logic [mdfs_pkg::OUT_COORD_W-1:0]    player_y,
  output logic [mdfs_pkg::WALL_W-1:0]         player_walls,
  output logic                                moved,
  // configuration port
  input  logic                                cfg_we,
  input  logic [mdfs_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [mdfs_pkg::REG_W-1:0]          cfg_data
);

  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int REG_W      = mdfs_pkg::REG_W;
  localparam int WLIM       = (MAX_WIDTH  < mdfs_pkg::REG_MAX) ? MAX_WIDTH  : mdfs_pkg::REG_MAX;
  localparam int HLIM       = (MAX_HEIGHT < mdfs_pkg::REG_MAX) ? MAX_HEIGHT : mdfs_pkg::REG_MAX;
  localparam int COL_W      = $clog2(WLIM);
  localparam int ROW_W      = $clog2(HLIM);
  localparam int CNT_W      = $clog2(IDX_W + 1);
  localparam int CMP_W      = ((IDX_W > REG_W) ? IDX_W : REG_W) + 1;
  localparam int PRD_W      = ROW_W + REG_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CELL_COUNT - 1);
  localparam logic [REG_W-1:0] WLIM_V    = REG_W'(WLIM);
  localparam logic [REG_W-1:0] HLIM_V    = REG_W'(HLIM);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(IDX_W - 1);

  typedef struct packed {
    logic [3:0]       walls;
    logic [3:0]       untried;
    logic             visited;
    logic [IDX_W-1:0] parent;
  } cell_t;

  // Configuration registers
  logic [REG_W-1:0] grid_width;
  logic [REG_W-1:0] grid_height;
  logic [REG_W-1:0] eff_w;
  logic [REG_W-1:0] eff_h;

  // Sequencer and walk state
  mdfs_pkg::state_t state, state_next;
  logic [IDX_W-1:0] cursor;
  logic             first_pass;
  logic             walk_finished;
  logic [COL_W-1:0] player_col;
  logic [ROW_W-1:0] player_row;
  logic [1:0]       dir_q;
  logic             move_pending;
  logic             moved_q;

  // Working registers
  cell_t            cur_cell;
  cell_t            nb_cell;
  logic [IDX_W-1:0] nb_idx;
  logic [IDX_W-1:0] div_dq;
  logic [REG_W-1:0] div_rem;
  logic [CNT_W-1:0] div_cnt;
  logic             div_build;
  logic [IDX_W-1:0] p_idx;
  logic             p_in;
  logic [3:0]       p_walls;

  // Sweep counters
  logic [IDX_W-1:0] sweep_idx;
  logic [COL_W-1:0] sweep_x;
  logic [ROW_W-1:0] sweep_y;
  logic             sweep_past;

  // Cell memory
  cell_t            mem [CELL_COUNT];
  cell_t            mem_rdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_we;
  cell_t            mem_wdata;

  // Combinational helpers
  logic [REG_W:0]   div_trial;
  logic             div_ge;
  logic [REG_W:0]   div_sub;
  logic [REG_W-1:0] div_rem_next;
  logic [3:0]       dir_bit;
  logic [3:0]       opp_bit;
  logic [CMP_W-1:0] bx_ext;
  logic [CMP_W-1:0] by_ext;
  logic [CMP_W-1:0] w_ext;
  logic [CMP_W-1:0] h_ext;
  logic             b_nb_ok;
  logic [IDX_W-1:0] b_nidx;
  logic [REG_W:0]   pc_ext;
  logic [REG_W:0]   pr_ext;
  logic             pm_ok;
  logic [COL_W-1:0] pm_col;
  logic [ROW_W-1:0] pm_row;
  logic             mv_ok;
  logic             sx_last;
  logic             sy_last;
  logic [3:0]       sweep_untried;
  logic             fin_c;

  // Clamp the grid registers to the usable range
  always_comb begin
    if (grid_width == '0) begin
      eff_w = REG_W'(1);
    end else if (grid_width > WLIM_V) begin
      eff_w = WLIM_V;
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == '0) begin
      eff_h = REG_W'(1);
    end else if (grid_height > HLIM_V) begin
      eff_h = HLIM_V;
    end else begin
      eff_h = grid_height;
    end
  end

  assign item_stall = (state != mdfs_pkg::ST_IDLE);

  // Restoring divider step: one quotient bit per cycle
  assign div_trial    = {div_rem, div_dq[IDX_W-1]};
  assign div_ge       = (div_trial >= {1'b0, eff_w});
  assign div_sub      = div_trial - {1'b0, eff_w};
  assign div_rem_next = div_ge ? div_sub[REG_W-1:0] : div_trial[REG_W-1:0];

  assign dir_bit = 4'b0001 << dir_q;
  assign opp_bit = 4'b0001 << (dir_q + 2'd2);

  // Build neighbour: cursor column is the remainder, row the quotient
  assign bx_ext = CMP_W'(div_rem);
  assign by_ext = CMP_W'(div_dq);
  assign w_ext  = CMP_W'(eff_w);
  assign h_ext  = CMP_W'(eff_h);

  always_comb begin
    case (dir_q)
      mdfs_pkg::DIR_N: begin
        b_nb_ok = (by_ext != '0) && ((by_ext - CMP_W'(1)) < h_ext);
        b_nidx  = cursor - IDX_W'(eff_w);
      end
      mdfs_pkg::DIR_E: begin
        b_nb_ok = ((bx_ext + CMP_W'(1)) < w_ext) && (by_ext < h_ext);
        b_nidx  = cursor + IDX_W'(1);
      end
      mdfs_pkg::DIR_S: begin
        b_nb_ok = ((by_ext + CMP_W'(1)) < h_ext);
        b_nidx  = cursor + IDX_W'(eff_w);
      end
      default: begin
        b_nb_ok = (bx_ext != '0) && (by_ext < h_ext);
        b_nidx  = cursor - IDX_W'(1);
      end
    endcase
  end

  // Player neighbour; a move is only taken when p_in shows the player inside the grid
  assign pc_ext = (REG_W+1)'(player_col);
  assign pr_ext = (REG_W+1)'(player_row);

  always_comb begin
    pm_col = player_col;
    pm_row = player_row;
    case (dir_q)
      mdfs_pkg::DIR_N: begin
        pm_ok  = (player_row != '0);
        pm_row = player_row - ROW_W'(1);
      end
      mdfs_pkg::DIR_E: begin
        pm_ok  = ((pc_ext + (REG_W+1)'(1)) < {1'b0, eff_w});
        pm_col = player_col + COL_W'(1);
      end
      mdfs_pkg::DIR_S: begin
        pm_ok  = ((pr_ext + (REG_W+1)'(1)) < {1'b0, eff_h});
        pm_row = player_row + ROW_W'(1);
      end
      default: begin
        pm_ok  = (player_col != '0);
        pm_col = player_col - COL_W'(1);
      end
    endcase
  end

  assign mv_ok = p_in && !mem_rdata.walls[dir_q] && pm_ok;

  // Start sweep: border-aware untried bits from the column and row counters
  assign sx_last = (((REG_W+1)'(sweep_x) + (REG_W+1)'(1)) == {1'b0, eff_w});
  assign sy_last = (((REG_W+1)'(sweep_y) + (REG_W+1)'(1)) == {1'b0, eff_h});
  assign sweep_untried = sweep_past ? 4'b0000 :
                         {(sweep_x != '0), !sy_last, !sx_last, (sweep_y != '0)};

  // Walk ends when the cursor sits on the root after the first carve
  assign fin_c = !first_pass && (mem_rdata.parent == cursor);

  // Next state and memory access control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cursor;
    mem_wdata  = cur_cell;
    mem_raddr  = cursor;
    case (state)
      mdfs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx;
        mem_wdata = '0;
        if (sweep_idx == LAST_IDX) begin
          state_next = mdfs_pkg::ST_IDLE;
        end
      end
      mdfs_pkg::ST_IDLE: begin
        if (item_valid) begin
          case (mode)
            mdfs_pkg::MODE_START: state_next = mdfs_pkg::ST_INIT;
            mdfs_pkg::MODE_BUILD: begin
              state_next = walk_finished ? mdfs_pkg::ST_T_LOAD : mdfs_pkg::ST_DIV;
            end
            mdfs_pkg::MODE_MOVE:  state_next = mdfs_pkg::ST_P_MUL;
            default:              state_next = mdfs_pkg::ST_T_LOAD;
          endcase
        end
      end
      mdfs_pkg::ST_INIT: begin
        mem_we            = 1'b1;
        mem_waddr         = sweep_idx;
        mem_wdata.walls   = 4'hF;
        mem_wdata.untried = sweep_untried;
        mem_wdata.visited = (sweep_idx == '0);
        mem_wdata.parent  = '0;
        if (sweep_idx == LAST_IDX) begin
          state_next = mdfs_pkg::ST_T_LOAD;
        end
      end
      mdfs_pkg::ST_T_LOAD: state_next = mdfs_pkg::ST_DIV;
      mdfs_pkg::ST_DIV: begin
        if (div_cnt == DIV_LAST) begin
          state_next = div_build ? mdfs_pkg::ST_B_RDC : mdfs_pkg::ST_P_MUL;
        end
      end
      mdfs_pkg::ST_B_RDC: state_next = mdfs_pkg::ST_B_EVC;
      mdfs_pkg::ST_B_EVC: begin
        if (mem_rdata.untried != 4'b0000) begin
          if ((mem_rdata.untried & dir_bit) != 4'b0000) begin
            if (b_nb_ok) begin
              state_next = mdfs_pkg::ST_B_RDN;
            end else begin
              // drop the tried direction: no neighbour there
              mem_we            = 1'b1;
              mem_wdata         = mem_rdata;
              mem_wdata.untried = mem_rdata.untried & ~dir_bit;
              state_next        = mdfs_pkg::ST_T_LOAD;
            end
          end else begin
            state_next = mdfs_pkg::ST_T_LOAD;
          end
        end else if (mem_rdata.parent == cursor) begin
          state_next = mdfs_pkg::ST_T_LOAD;
        end else begin
          state_next = mdfs_pkg::ST_B_RDP;
        end
      end
      mdfs_pkg::ST_B_RDN: begin
        mem_raddr  = nb_idx;
        state_next = mdfs_pkg::ST_B_EVN;
      end
      mdfs_pkg::ST_B_EVN: begin
        // write back the current cell; open its wall when carving
        mem_we            = 1'b1;
        mem_wdata.untried = cur_cell.untried & ~dir_bit;
        if (!mem_rdata.visited) begin
          mem_wdata.walls = cur_cell.walls & ~dir_bit;
          state_next      = mdfs_pkg::ST_B_WRN;
        end else begin
          state_next      = mdfs_pkg::ST_T_LOAD;
        end
      end
      mdfs_pkg::ST_B_WRN: begin
        mem_we            = 1'b1;
        mem_waddr         = nb_idx;
        mem_wdata         = nb_cell;
        mem_wdata.walls   = nb_cell.walls & ~opp_bit;
        mem_wdata.visited = 1'b1;
        mem_wdata.parent  = cursor;
        state_next        = mdfs_pkg::ST_T_LOAD;
      end
      mdfs_pkg::ST_B_RDP: state_next = mdfs_pkg::ST_B_EVP;
      mdfs_pkg::ST_B_EVP: state_next = mdfs_pkg::ST_T_LOAD;
      mdfs_pkg::ST_P_MUL: state_next = mdfs_pkg::ST_P_RD;
      mdfs_pkg::ST_P_RD: begin
        mem_raddr  = p_idx;
        state_next = mdfs_pkg::ST_P_EV;
      end
      mdfs_pkg::ST_P_EV: begin
        state_next = move_pending ? mdfs_pkg::ST_T_LOAD : mdfs_pkg::ST_OUT;
      end
      mdfs_pkg::ST_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = mdfs_pkg::ST_IDLE;
        end
      end
      default: state_next = mdfs_pkg::ST_IDLE;
    endcase
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdfs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= mdfs_pkg::GRID_RESET;
      grid_height <= mdfs_pkg::GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mdfs_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data;
        mdfs_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Walk and player state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor        <= '0;
      first_pass    <= 1'b1;
      walk_finished <= 1'b0;
      player_col    <= '0;
      player_row    <= '0;
      move_pending  <= 1'b0;
      sweep_idx     <= '0;
      div_cnt       <= '0;
    end else begin
      case (state)
        mdfs_pkg::ST_CLEAR: sweep_idx <= sweep_idx + IDX_W'(1);
        mdfs_pkg::ST_IDLE: begin
          div_cnt <= '0;
          if (item_valid) begin
            if (mode == mdfs_pkg::MODE_START) begin
              cursor        <= '0;
              first_pass    <= 1'b1;
              walk_finished <= 1'b0;
              player_col    <= '0;
              player_row    <= '0;
              sweep_idx     <= '0;
            end
            move_pending <= (mode == mdfs_pkg::MODE_MOVE);
          end
        end
        mdfs_pkg::ST_INIT:   sweep_idx <= sweep_idx + IDX_W'(1);
        mdfs_pkg::ST_T_LOAD: div_cnt   <= '0;
        mdfs_pkg::ST_DIV:    div_cnt   <= div_cnt + CNT_W'(1);
        mdfs_pkg::ST_B_EVC: begin
          if (mem_rdata.untried != 4'b0000) begin
            // skip or reject: cursor stays, check for the root
            if (((mem_rdata.untried & dir_bit) == 4'b0000 || !b_nb_ok) && fin_c) begin
              walk_finished <= 1'b1;
            end
          end else if (mem_rdata.parent == cursor) begin
            walk_finished <= 1'b1;
          end else begin
            // backtrack
            cursor <= mem_rdata.parent;
          end
        end
        mdfs_pkg::ST_B_EVN: begin
          if (mem_rdata.visited && !first_pass && (cur_cell.parent == cursor)) begin
            walk_finished <= 1'b1;
          end
        end
        mdfs_pkg::ST_B_WRN: begin
          cursor     <= nb_idx;
          first_pass <= 1'b0;
        end
        mdfs_pkg::ST_B_EVP: begin
          if (fin_c) begin
            walk_finished <= 1'b1;
          end
        end
        mdfs_pkg::ST_P_EV: begin
          if (move_pending) begin
            move_pending <= 1'b0;
            if (mv_ok) begin
              player_col <= pm_col;
              player_row <= pm_row;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mdfs_pkg::ST_IDLE: begin
        dir_q     <= dir;
        moved_q   <= 1'b0;
        div_dq    <= cursor;
        div_rem   <= '0;
        div_build <= 1'b1;
        sweep_x   <= '0;
        sweep_y   <= '0;
        sweep_past <= 1'b0;
        if (mode == mdfs_pkg::MODE_START) begin
          div_dq <= '0;
        end
      end
      mdfs_pkg::ST_INIT: begin
        // advance the column and row counters
        if (sx_last) begin
          sweep_x <= '0;
          if (sy_last) begin
            sweep_past <= 1'b1;
          end else begin
            sweep_y <= sweep_y + ROW_W'(1);
          end
        end else begin
          sweep_x <= sweep_x + COL_W'(1);
        end
      end
      mdfs_pkg::ST_T_LOAD: begin
        div_dq    <= cursor;
        div_rem   <= '0;
        div_build <= 1'b0;
      end
      mdfs_pkg::ST_DIV: begin
        div_dq  <= {div_dq[IDX_W-2:0], div_ge};
        div_rem <= div_rem_next;
      end
      mdfs_pkg::ST_B_EVC: begin
        cur_cell <= mem_rdata;
        nb_idx   <= b_nidx;
      end
      mdfs_pkg::ST_B_EVN: nb_cell <= mem_rdata;
      mdfs_pkg::ST_P_MUL: begin
        p_in  <= (pc_ext < {1'b0, eff_w}) && (pr_ext < {1'b0, eff_h});
        p_idx <= IDX_W'(PRD_W'(player_col) + PRD_W'(player_row) * PRD_W'(eff_w));
      end
      mdfs_pkg::ST_P_EV: begin
        p_walls <= p_in ? mem_rdata.walls : 4'hF;
        if (move_pending && mv_ok) begin
          moved_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register: hold while stalled, load from the final state
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (state == mdfs_pkg::ST_OUT && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mdfs_pkg::ST_OUT && (!result_valid || !result_stall)) begin
      build_done   <= walk_finished;
      cursor_x     <= mdfs_pkg::OUT_COORD_W'(div_rem);
      cursor_y     <= mdfs_pkg::OUT_COORD_W'(div_dq);
      player_x     <= mdfs_pkg::OUT_COORD_W'(player_col);
      player_y     <= mdfs_pkg::OUT_COORD_W'(player_row);
      player_walls <= p_walls;
      moved        <= moved_q;
    end
  end

  // A finished walk ignores further build items
  a_finished_hold: assert property (@(posedge clk) disable iff (rst)
    (state == mdfs_pkg::ST_IDLE && item_valid && mode == mdfs_pkg::MODE_BUILD &&
     walk_finished) |=> $stable(cursor))
    else $error("cursor moved after the walk finished");

  // A start item restarts the walk at the root
  a_start_root: assert property (@(posedge clk) disable iff (rst)
    (state == mdfs_pkg::ST_IDLE && item_valid && mode == mdfs_pkg::MODE_START) |=>
    (first_pass && !walk_finished && cursor == '0))
    else $error("start item did not reset the walk");

  // A carve moves the cursor into the new cell and leaves the walk open
  a_carve: assert property (@(posedge clk) disable iff (rst)
    (state == mdfs_pkg::ST_B_WRN) |=>
    (cursor == $past(nb_idx) && !first_pass && !walk_finished))
    else $error("carve did not advance the cursor");

  // Results only come from the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == mdfs_pkg::ST_OUT)
    else $error("result raised outside the output state");

  // The cell memory is never written while waiting for items or results
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == mdfs_pkg::ST_IDLE || state == mdfs_pkg::ST_OUT) |-> !mem_we)
    else $error("cell memory written while idle");

endmodule
`default_nettype wire
